>>> design/cpfc_pkg.sv
// ----------------------------------------------------------------------------
// cpfc_pkg
// shared types, codes and the crc-16 (0x1021, msb first) byte update for the
// packet framer and response checker
// ----------------------------------------------------------------------------
package cpfc_pkg;

	localparam int unsigned MaxRespLenDefault = 255;
	localparam logic [15:0] CrcPoly           = 16'h1021;
	localparam logic [7:0]  DevAddrReset      = 8'd128;
	localparam logic [15:0] CrcInitReset      = 16'h0000;
	localparam int unsigned RemW              = 8;
	localparam int unsigned CfgIdxW           = 2;
	localparam int unsigned MaxResults        = 4;
	localparam int unsigned CntW              = 3;
	localparam int unsigned SlotW             = 2;

	typedef enum logic [1:0] {
		KIND_TX    = 2'd0,
		KIND_RX    = 2'd1,
		KIND_CHECK = 2'd2
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEVICE_ADDRESS = 2'd0,
		CFG_CRC_INIT       = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_DATA = 4'b0010,
		PH_CRCH = 4'b0100,
		PH_CRCL = 4'b1000
	} rx_phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       is_first;
		logic       is_last;
		logic [7:0] resp_len;
	} item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       crc_ok;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [CntW-1:0]                count;
		result_t [MaxResults-1:0]       items;
	} bundle_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> design/cpfc_core.sv
// ----------------------------------------------------------------------------
// cpfc_core
// configuration registers, framing and checking state, and the per-beat
// result bundle (up to four results) for the held input beat
// ----------------------------------------------------------------------------
module cpfc_core #(
	parameter int unsigned MAX_RESP_LEN = cpfc_pkg::MaxRespLenDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cpfc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [15:0]                      cfg_data,
	input  cpfc_pkg::item_t                  item_s1,
	input  logic                             fire,
	output cpfc_pkg::bundle_t                bundle
);

	logic [7:0]                    dev_addr_q;
	logic [15:0]                   crc_init_q;
	logic [15:0]                   tx_crc_q;
	logic [15:0]                   rx_crc_q;
	logic [cpfc_pkg::RemW-1:0]     rx_rem_q;
	logic [7:0]                    rx_high_q;
	cpfc_pkg::rx_phase_t           rx_phase_q;

	logic [15:0]                   tx_base;
	logic [15:0]                   tx_crc_nxt;
	logic [cpfc_pkg::SlotW-1:0]    slot;
	logic [cpfc_pkg::RemW-1:0]     rlen_sat;
	logic [cpfc_pkg::RemW-1:0]     rem_eff;
	logic [cpfc_pkg::RemW-1:0]     rem_nxt;
	logic [15:0]                   rx_crc_eff;
	logic [15:0]                   rx_crc_nxt;
	logic [7:0]                    rx_high_nxt;
	cpfc_pkg::rx_phase_t           phase_eff;
	cpfc_pkg::rx_phase_t           phase_nxt;
	cpfc_pkg::bundle_t             tx_bundle;
	cpfc_pkg::bundle_t             rx_bundle;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= cpfc_pkg::DevAddrReset;
			crc_init_q <= cpfc_pkg::CrcInitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				cpfc_pkg::CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[7:0];
				cpfc_pkg::CFG_CRC_INIT:       crc_init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// transmit framing
	always_comb begin
		tx_base    = item_s1.is_first ? cpfc_pkg::crc16_byte(crc_init_q, dev_addr_q) : tx_crc_q;
		tx_crc_nxt = cpfc_pkg::crc16_byte(tx_base, item_s1.data_byte);
		tx_bundle  = '0;
		slot       = item_s1.is_first ? cpfc_pkg::SlotW'(1) : cpfc_pkg::SlotW'(0);
		if (item_s1.is_first) begin
			tx_bundle.items[0].out_kind = cpfc_pkg::KIND_TX;
			tx_bundle.items[0].out_byte = dev_addr_q;
		end
		tx_bundle.items[slot].out_kind = cpfc_pkg::KIND_TX;
		tx_bundle.items[slot].out_byte = item_s1.data_byte;
		tx_bundle.items[slot].last     = ~item_s1.is_last;
		if (item_s1.is_last) begin
			tx_bundle.items[slot + cpfc_pkg::SlotW'(1)].out_kind = cpfc_pkg::KIND_TX;
			tx_bundle.items[slot + cpfc_pkg::SlotW'(1)].out_byte = tx_crc_nxt[15:8];
			tx_bundle.items[slot + cpfc_pkg::SlotW'(2)].out_kind = cpfc_pkg::KIND_TX;
			tx_bundle.items[slot + cpfc_pkg::SlotW'(2)].out_byte = tx_crc_nxt[7:0];
			tx_bundle.items[slot + cpfc_pkg::SlotW'(2)].last     = 1'b1;
		end
		tx_bundle.count = cpfc_pkg::CntW'(1)
			+ (item_s1.is_first ? cpfc_pkg::CntW'(1) : cpfc_pkg::CntW'(0))
			+ (item_s1.is_last ? cpfc_pkg::CntW'(2) : cpfc_pkg::CntW'(0));
	end

	// receive checking
	always_comb begin
		rlen_sat = ({24'd0, item_s1.resp_len} > 32'(MAX_RESP_LEN))
			? cpfc_pkg::RemW'(MAX_RESP_LEN) : item_s1.resp_len;
		if (item_s1.is_first) begin
			rem_eff    = rlen_sat;
			rx_crc_eff = crc_init_q;
			phase_eff  = (rlen_sat != '0) ? cpfc_pkg::PH_DATA : cpfc_pkg::PH_CRCH;
		end else begin
			rem_eff    = rx_rem_q;
			rx_crc_eff = rx_crc_q;
			phase_eff  = rx_phase_q;
		end
		rem_nxt     = rem_eff;
		rx_crc_nxt  = rx_crc_eff;
		rx_high_nxt = rx_high_q;
		phase_nxt   = phase_eff;
		rx_bundle   = '0;
		case (phase_eff)
			cpfc_pkg::PH_DATA: begin
				rx_crc_nxt                  = cpfc_pkg::crc16_byte(rx_crc_eff, item_s1.data_byte);
				rx_bundle.count             = cpfc_pkg::CntW'(1);
				rx_bundle.items[0].out_kind = cpfc_pkg::KIND_RX;
				rx_bundle.items[0].out_byte = item_s1.data_byte;
				rx_bundle.items[0].last     = 1'b1;
				if (rem_eff != '0) begin
					rem_nxt = rem_eff - cpfc_pkg::RemW'(1);
				end
				if (rem_nxt == '0) begin
					phase_nxt = cpfc_pkg::PH_CRCH;
				end
			end
			cpfc_pkg::PH_CRCH: begin
				rx_high_nxt = item_s1.data_byte;
				phase_nxt   = cpfc_pkg::PH_CRCL;
			end
			cpfc_pkg::PH_CRCL: begin
				rx_bundle.count             = cpfc_pkg::CntW'(1);
				rx_bundle.items[0].out_kind = cpfc_pkg::KIND_CHECK;
				rx_bundle.items[0].crc_ok   = ({rx_high_q, item_s1.data_byte} == rx_crc_eff);
				rx_bundle.items[0].last     = 1'b1;
				phase_nxt                   = cpfc_pkg::PH_IDLE;
			end
			default: ;
		endcase
	end

	assign bundle = item_s1.req_type ? rx_bundle : tx_bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_crc_q   <= cpfc_pkg::CrcInitReset;
			rx_crc_q   <= cpfc_pkg::CrcInitReset;
			rx_rem_q   <= '0;
			rx_high_q  <= '0;
			rx_phase_q <= cpfc_pkg::PH_IDLE;
		end else if (fire) begin
			if (item_s1.req_type) begin
				rx_crc_q   <= rx_crc_nxt;
				rx_rem_q   <= rem_nxt;
				rx_high_q  <= rx_high_nxt;
				rx_phase_q <= phase_nxt;
			end else begin
				tx_crc_q <= tx_crc_nxt;
			end
		end
	end

endmodule

>>> design/cpfc_obuf.sv
// ----------------------------------------------------------------------------
// cpfc_obuf
// result register bank: takes a bundle of up to four results and hands them
// out one beat at a time
// ----------------------------------------------------------------------------
module cpfc_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cpfc_pkg::bundle_t   bundle,
	output logic                free,
	output logic                result_valid,
	input  logic                result_stall,
	output cpfc_pkg::result_t   result
);

	cpfc_pkg::result_t [cpfc_pkg::MaxResults-1:0] items_q;
	logic [cpfc_pkg::CntW-1:0]                    rem_q;
	logic [cpfc_pkg::SlotW-1:0]                   idx_q;
	logic                                         pop;

	assign result_valid = (rem_q != '0);
	assign pop          = result_valid & ~result_stall;
	assign free         = (rem_q == '0) | ((rem_q == cpfc_pkg::CntW'(1)) & pop);
	assign result       = items_q[idx_q];

	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= bundle.items;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= bundle.count;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - cpfc_pkg::CntW'(1);
			idx_q <= idx_q + cpfc_pkg::SlotW'(1);
		end
	end

endmodule

>>> design/crc16_packet_framer_checker_unit.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer_checker_unit
// frames transmit bytes with address and crc-16 trailer, checks received
// responses against their crc-16 trailer
//
// channel   signals                           direction
// item      item_valid / item_stall / item    beats in
// result    result_valid / result_stall / result  beats out
// cfg       cfg_valid / cfg_ready / cfg_index / cfg_data  register writes
//
// an input beat is registered, then evaluated combinationally into up to
// four results, which leave the result registers one per cycle unless
// stalled; a beat giving one result or none sustains one beat per cycle
// unless stalled; a beat giving n results holds the next beat in the input
// register until its last result leaves; no clearing pass
// result_stall holds the result bank, and item_stall follows once it is full
// ----------------------------------------------------------------------------
module crc16_packet_framer_checker_unit #(
	parameter int unsigned MAX_RESP_LEN = cpfc_pkg::MaxRespLenDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  cpfc_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output cpfc_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cpfc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [15:0]                   cfg_data
);

	cpfc_pkg::item_t    item_s1;
	logic               valid_s1;
	logic               free;
	logic               fire;
	cpfc_pkg::bundle_t  bundle;

	assign cfg_ready  = 1'b1;
	assign fire       = valid_s1 & free;
	assign item_stall = valid_s1 & ~free;

	always_ff @(posedge clk) begin
		if (item_valid & ~item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid & ~item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	cpfc_core #(
		.MAX_RESP_LEN(MAX_RESP_LEN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item_s1  (item_s1),
		.fire     (fire),
		.bundle   (bundle)
	);

	cpfc_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (fire),
		.bundle      (bundle),
		.free        (free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
